// ===== src/uartrxfa_pkg.sv =====
// ----------------------------------------------------------------------------
// UART receive frame assembler package
// Item modes, register indexes and response word layout.
// ----------------------------------------------------------------------------
package uartrxfa_pkg;

   typedef enum logic [1:0] {
      MODE_BYTE    = 2'd0,
      MODE_TICK    = 2'd1,
      MODE_RELEASE = 2'd2,
      MODE_READ    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CSR_TIMEOUT_RELOAD = 2'd0,
      CSR_TERM_ENABLE    = 2'd1,
      CSR_TERM_FIRST     = 2'd2,
      CSR_TERM_SECOND    = 2'd3
   } csr_index_type;

   localparam logic [6:0] TIMEOUT_RELOAD_RST = 7'd10;
   localparam logic       TERM_ENABLE_RST    = 1'b1;
   localparam logic [7:0] TERM_FIRST_RST     = 8'h0D;
   localparam logic [7:0] TERM_SECOND_RST    = 8'h09;

   localparam int unsigned RSP_WIDTH      = 24;
   localparam int unsigned RSP_READY_BIT  = 0;
   localparam int unsigned RSP_LEN_LSB    = 1;
   localparam int unsigned RSP_RECV_BIT   = 10;
   localparam int unsigned RSP_STORED_BIT = 11;
   localparam int unsigned RSP_DATA_LSB   = 12;

endpackage

// ===== src/uart_rx_frame_assembler.sv =====
// ----------------------------------------------------------------------------
// UART receive frame assembler
// Collects received bytes into a frame store; closes frames on idle timeout,
// on a two-byte terminator or on a full store.
// ----------------------------------------------------------------------------
// Response: the response word is registered and appears in the cycle after the
// request word. Throughput: one word per cycle unless the response side stalls;
// the frame store RAM takes one write and one registered read per cycle.
// Reset: synchronous; clears control state and registers to their defaults.
// The frame store is not cleared, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
module uart_rx_frame_assembler #(
   parameter int unsigned BUF_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] byte_value, [15:8] read_index
   input  logic [1:0]  req_tuser,   // [1:0] mode
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [0] frame_ready, [9:1] frame_length,
                                    // [10] receiving, [11] byte_stored,
                                    // [19:12] read_data, [23:20] zero
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int unsigned IDX_W = $clog2(BUF_DEPTH);
   localparam int unsigned LEN_W = $clog2(BUF_DEPTH + 1);
   localparam int unsigned RI_W  = ((IDX_W > 8) ? IDX_W : 8) + 1;

   // registers
   logic [6:0]       timeout_reload_ff;
   logic             term_enable_ff;
   logic [7:0]       term_first_ff;
   logic [7:0]       term_second_ff;

   // frame state
   logic [IDX_W-1:0] write_index_ff,  write_index_in;
   logic             ready_ff,        ready_in;
   logic [LEN_W-1:0] length_ff,       length_in;
   logic             collecting_ff,   collecting_in;
   logic [6:0]       idle_ff,         idle_in;
   logic [7:0]       prev_byte_ff,    prev_byte_in;

   // response stage
   logic             rsp_valid_ff,    rsp_valid_in;
   logic             rsp_ready_ff;
   logic [LEN_W-1:0] rsp_length_ff;
   logic             rsp_recv_ff;
   logic             rsp_stored_ff;
   logic             rsp_rd_sel_ff;

   uartrxfa_pkg::mode_type mode;
   logic [7:0]       byte_value;
   logic [RI_W-1:0]  read_index_ext;
   logic             read_in_range;
   logic             accept;
   logic             stored;
   logic [LEN_W-1:0] index_next;
   logic             term_hit;
   logic [7:0]       ram_q;
   logic [LEN_W+8:0] length_ext;

   assign mode           = uartrxfa_pkg::mode_type'(req_tuser);
   assign byte_value     = req_tdata[7:0];
   assign read_index_ext = RI_W'(req_tdata[15:8]);
   assign read_in_range  = read_index_ext < RI_W'(BUF_DEPTH);

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign index_next = LEN_W'(write_index_ff) + LEN_W'(1);
   assign term_hit   = (write_index_ff != '0) && term_enable_ff &&
                       (prev_byte_ff == term_first_ff) &&
                       (byte_value == term_second_ff);

   always_comb begin
      write_index_in = write_index_ff;
      ready_in       = ready_ff;
      length_in      = length_ff;
      collecting_in  = collecting_ff;
      idle_in        = idle_ff;
      prev_byte_in   = prev_byte_ff;
      stored         = 1'b0;
      unique case (mode)
         uartrxfa_pkg::MODE_BYTE: begin
            if (ready_ff) begin
               collecting_in = 1'b0;
               idle_in       = timeout_reload_ff;
            end else if ((write_index_ff != '0) && (idle_ff == '0)) begin
               // timeout: drop this byte
               ready_in       = 1'b1;
               collecting_in  = 1'b0;
               length_in      = LEN_W'(write_index_ff);
               write_index_in = '0;
            end else begin
               if (write_index_ff == '0) begin
                  collecting_in = 1'b1;
               end
               idle_in      = timeout_reload_ff;
               prev_byte_in = byte_value;
               stored       = 1'b1;
               if (term_hit || (index_next == LEN_W'(BUF_DEPTH))) begin
                  ready_in       = 1'b1;
                  collecting_in  = 1'b0;
                  length_in      = index_next;
                  write_index_in = '0;
               end else begin
                  write_index_in = index_next[IDX_W-1:0];
               end
            end
         end
         uartrxfa_pkg::MODE_TICK: begin
            if (idle_ff != '0) begin
               idle_in = idle_ff - 7'd1;
            end
         end
         uartrxfa_pkg::MODE_RELEASE: begin
            ready_in = 1'b0;
         end
         uartrxfa_pkg::MODE_READ: begin
         end
         default: begin
         end
      endcase
   end

   uartrxfa_ram #(
      .WIDTH (8),
      .DEPTH (BUF_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept && stored),
      .wr_addr (write_index_ff),
      .wr_data (byte_value),
      .rd_en   (accept),
      .rd_addr (read_index_ext[IDX_W-1:0]),
      .rd_data (ram_q)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_reload_ff <= uartrxfa_pkg::TIMEOUT_RELOAD_RST;
         term_enable_ff    <= uartrxfa_pkg::TERM_ENABLE_RST;
         term_first_ff     <= uartrxfa_pkg::TERM_FIRST_RST;
         term_second_ff    <= uartrxfa_pkg::TERM_SECOND_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (uartrxfa_pkg::csr_index_type'(csr_index))
            uartrxfa_pkg::CSR_TIMEOUT_RELOAD: timeout_reload_ff <= csr_wdata[6:0];
            uartrxfa_pkg::CSR_TERM_ENABLE:    term_enable_ff    <= csr_wdata[0];
            uartrxfa_pkg::CSR_TERM_FIRST:     term_first_ff     <= csr_wdata;
            uartrxfa_pkg::CSR_TERM_SECOND:    term_second_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_index_ff <= '0;
         ready_ff       <= 1'b0;
         length_ff      <= '0;
         collecting_ff  <= 1'b0;
         idle_ff        <= '0;
         prev_byte_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            write_index_ff <= write_index_in;
            ready_ff       <= ready_in;
            length_ff      <= length_in;
            collecting_ff  <= collecting_in;
            idle_ff        <= idle_in;
            prev_byte_ff   <= prev_byte_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ready_ff  <= ready_in;
         rsp_length_ff <= length_in;
         rsp_recv_ff   <= collecting_in;
         rsp_stored_ff <= stored;
         rsp_rd_sel_ff <= (mode == uartrxfa_pkg::MODE_READ) && read_in_range;
      end
   end

   assign length_ext = (LEN_W + 9)'(rsp_length_ff);

   assign rsp_tvalid = rsp_valid_ff;
   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[uartrxfa_pkg::RSP_READY_BIT]                    = rsp_ready_ff;
      rsp_tdata[uartrxfa_pkg::RSP_LEN_LSB +: 9]                 = length_ext[8:0];
      rsp_tdata[uartrxfa_pkg::RSP_RECV_BIT]                     = rsp_recv_ff;
      rsp_tdata[uartrxfa_pkg::RSP_STORED_BIT]                   = rsp_stored_ff;
      rsp_tdata[uartrxfa_pkg::RSP_DATA_LSB +: 8]                = rsp_rd_sel_ff ? ram_q : 8'h00;
   end

endmodule

// ===== src/uartrxfa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, registered-read RAM
// One write and one read per cycle; read data holds while rd_en is low.
// ----------------------------------------------------------------------------
module uartrxfa_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/uartrxfa_checker.sv =====
// ----------------------------------------------------------------------------
// UART receive frame assembler checker
// Port-level properties of the response stream, bound to the top level.
// ----------------------------------------------------------------------------
module uartrxfa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   // every accepted request yields a response word next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request produced no response");

   // a waiting frame and an open frame exclude each other
   a_ready_vs_recv: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[uartrxfa_pkg::RSP_READY_BIT] &&
                       rsp_tdata[uartrxfa_pkg::RSP_RECV_BIT]))
      else $error("frame_ready and receiving both set");

   // a stored byte never comes with read data
   a_stored_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[uartrxfa_pkg::RSP_STORED_BIT] |->
         rsp_tdata[uartrxfa_pkg::RSP_DATA_LSB +: 8] == 8'h00)
      else $error("byte_stored with nonzero read_data");

endmodule

bind uart_rx_frame_assembler uartrxfa_checker u_uartrxfa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== test/tb_uart_rx_frame_assembler.sv =====
// ----------------------------------------------------------------------------
// UART receive frame assembler testbench
// Drives byte, tick, release and read words through the request stream and
// checks every response word against a cycle-free predictor of the frame
// logic. A short scripted sequence hits the reset state, the terminator, the
// idle timeout, a zero reload and a full store; random phases then sweep the
// register settings with bursty requests and a stalling response side.
// ----------------------------------------------------------------------------
module tb_uart_rx_frame_assembler;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH  = 256;
   localparam int QUIET_LIMIT  = 4000;
   localparam int PHASE_COUNT  = 10;
   localparam int PHASE_WORDS  = 145;

   typedef struct packed {
      logic       ready;
      logic [8:0] length;
      logic       recv;
      logic       stored;
      logic [7:0] data;
   } frame_status_type;

   typedef struct {
      bit                          is_csr;
      uartrxfa_pkg::csr_index_type reg_idx;
      logic [7:0]                  reg_val;
      uartrxfa_pkg::mode_type      mode;
      logic [7:0]                  bval;
      logic [7:0]                  ridx;
      bit                          known;
      frame_status_type            want;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [7:0] byte_value, [15:8] read_index
   logic [1:0]  req_tuser;   // [1:0] mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;   // [0] frame_ready, [9:1] frame_length, [10] receiving,
                             // [11] byte_stored, [19:12] read_data
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [7:0]  csr_wdata;

   // predictor state
   logic [7:0] frame_mem [STORE_DEPTH];
   bit         written_mask [STORE_DEPTH];
   int         wr_ptr;
   int         last_wr_index;
   bit         frame_waiting;
   logic [8:0] held_length;
   bit         collecting;
   logic [6:0] idle_left;
   logic [7:0] last_byte;
   logic [6:0] cfg_reload;
   bit         cfg_term_en;
   logic [7:0] cfg_term_a;
   logic [7:0] cfg_term_b;

   frame_status_type status_queue[$];
   script_row_type   script[$];

   int burst_left;
   int phase_words;
   int sent_words;
   int bytes_stored;
   int closes_term;
   int closes_idle;
   int closes_full;
   int csr_writes;
   int rsp_count;
   int mismatch_count;
   int quiet_cycles;

   int       stall_span;
   int       stall_style;
   bit [2:0] stall_phase;

   uart_rx_frame_assembler #(.BUF_DEPTH(STORE_DEPTH)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic void close_frame(int len);
      frame_waiting = 1'b1;
      collecting    = 1'b0;
      held_length   = len[8:0];
      wr_ptr        = 0;
   endfunction

   function automatic frame_status_type assemble_step(uartrxfa_pkg::mode_type m,
                                                      logic [7:0] b, logic [7:0] ri);
      frame_status_type st;
      logic [7:0]       prior;
      st = '0;
      case (m)
         uartrxfa_pkg::MODE_BYTE: begin
            if (frame_waiting) begin
               collecting = 1'b0;
               idle_left  = cfg_reload;
            end else if (wr_ptr != 0 && idle_left == 0) begin
               close_frame(wr_ptr);
               closes_idle++;
            end else begin
               if (wr_ptr == 0)
                  collecting = 1'b1;
               idle_left = cfg_reload;
               if (wr_ptr >= STORE_DEPTH)
                  wr_ptr = 0;
               frame_mem[wr_ptr]    = b;
               written_mask[wr_ptr] = 1'b1;
               last_wr_index        = wr_ptr;
               prior     = last_byte;
               last_byte = b;
               wr_ptr++;
               st.stored = 1'b1;
               bytes_stored++;
               if (wr_ptr >= 2 && cfg_term_en && prior == cfg_term_a && b == cfg_term_b) begin
                  close_frame(wr_ptr);
                  closes_term++;
               end else if (wr_ptr >= STORE_DEPTH) begin
                  close_frame(STORE_DEPTH);
                  closes_full++;
               end
            end
         end
         uartrxfa_pkg::MODE_TICK: begin
            if (idle_left > 0)
               idle_left--;
         end
         uartrxfa_pkg::MODE_RELEASE: begin
            frame_waiting = 1'b0;
         end
         default: begin
            if (ri < STORE_DEPTH)
               st.data = frame_mem[ri];
         end
      endcase
      st.ready  = frame_waiting;
      st.length = held_length;
      st.recv   = collecting;
      return st;
   endfunction

   function automatic void add_word(uartrxfa_pkg::mode_type m, logic [7:0] b, logic [7:0] ri,
                                    bit known, logic ready, logic [8:0] len, logic recv,
                                    logic stored, logic [7:0] data);
      script_row_type row;
      row.is_csr  = 1'b0;
      row.reg_idx = uartrxfa_pkg::CSR_TIMEOUT_RELOAD;
      row.reg_val = '0;
      row.mode    = m;
      row.bval    = b;
      row.ridx    = ri;
      row.known   = known;
      row.want    = '{ready: ready, length: len, recv: recv, stored: stored, data: data};
      script.push_back(row);
   endfunction

   function automatic void add_csr(uartrxfa_pkg::csr_index_type ci, logic [7:0] v);
      script_row_type row;
      row.is_csr  = 1'b1;
      row.reg_idx = ci;
      row.reg_val = v;
      row.mode    = uartrxfa_pkg::MODE_TICK;
      row.bval    = '0;
      row.ridx    = '0;
      row.known   = 1'b0;
      row.want    = '0;
      script.push_back(row);
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatch_count < 40)
         $display("mismatch on response %0d: %s", rsp_count, msg);
      mismatch_count++;
   endtask

   task automatic send_word(uartrxfa_pkg::mode_type m, logic [7:0] b, logic [7:0] ri,
                            bit known, frame_status_type want);
      frame_status_type predicted;
      logic [7:0]       b_out;
      logic [7:0]       ri_out;
      b_out  = (m == uartrxfa_pkg::MODE_BYTE) ? b : 8'($urandom);
      ri_out = (m == uartrxfa_pkg::MODE_READ) ? ri : 8'($urandom);
      if (!(m == uartrxfa_pkg::MODE_BYTE && frame_waiting))
         phase_words++;
      sent_words++;
      predicted = assemble_step(m, b_out, ri_out);
      @(negedge clock);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                  : $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ri_out, b_out};
      req_tuser  <= m;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      status_queue.push_back(known ? want : predicted);
   endtask

   task automatic settle_block();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (status_queue.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_csr(uartrxfa_pkg::csr_index_type ci, logic [7:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= ci;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (ci)
         uartrxfa_pkg::CSR_TIMEOUT_RELOAD: cfg_reload  = v[6:0];
         uartrxfa_pkg::CSR_TERM_ENABLE:    cfg_term_en = v[0];
         uartrxfa_pkg::CSR_TERM_FIRST:     cfg_term_a  = v;
         default:                          cfg_term_b  = v;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic read_stored_byte();
      logic [7:0] idx;
      idx = 8'($urandom);
      if (!written_mask[idx])
         idx = last_wr_index[7:0];
      send_word(uartrxfa_pkg::MODE_READ, 8'h00, idx, 1'b0, '0);
   endtask

   // response side: stall in one of three styles, picked anew after each random span
   always @(negedge clock) begin
      if (stall_span == 0) begin
         stall_style <= $urandom_range(0, 2);
         stall_span  <= $urandom_range(20, 120);
      end else begin
         stall_span <= stall_span - 1;
      end
      case (stall_style)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= (stall_phase < 3'd5);
      endcase
      stall_phase <= stall_phase + 3'd1;
   end

   always @(posedge clock) begin : check_rsp
      frame_status_type seen;
      frame_status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.ready  = rsp_tdata[uartrxfa_pkg::RSP_READY_BIT];
         seen.length = rsp_tdata[uartrxfa_pkg::RSP_LEN_LSB +: 9];
         seen.recv   = rsp_tdata[uartrxfa_pkg::RSP_RECV_BIT];
         seen.stored = rsp_tdata[uartrxfa_pkg::RSP_STORED_BIT];
         seen.data   = rsp_tdata[uartrxfa_pkg::RSP_DATA_LSB +: 8];
         if (status_queue.size() == 0) begin
            report_mismatch("response word with nothing pending");
         end else begin
            want = status_queue.pop_front();
            if (seen.ready !== want.ready)
               report_mismatch($sformatf("frame_ready %b, want %b", seen.ready, want.ready));
            if (seen.length !== want.length)
               report_mismatch($sformatf("frame_length %0d, want %0d",
                                         seen.length, want.length));
            if (seen.recv !== want.recv)
               report_mismatch($sformatf("receiving %b, want %b", seen.recv, want.recv));
            if (seen.stored !== want.stored)
               report_mismatch($sformatf("byte_stored %b, want %b", seen.stored, want.stored));
            if (seen.data !== want.data)
               report_mismatch($sformatf("read_data %02h, want %02h", seen.data, want.data));
         end
         rsp_count++;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("no handshake for %0d cycles", QUIET_LIMIT);
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int         phase;
      int         pick;
      int         n;
      logic [7:0] bv;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = uartrxfa_pkg::MODE_BYTE;
      csr_valid  = 1'b0;
      csr_index  = uartrxfa_pkg::CSR_TIMEOUT_RELOAD;
      csr_wdata  = '0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         frame_mem[i]    = '0;
         written_mask[i] = 1'b0;
      end
      wr_ptr         = 0;
      last_wr_index  = 0;
      frame_waiting  = 1'b0;
      held_length    = '0;
      collecting     = 1'b0;
      idle_left      = '0;
      last_byte      = '0;
      cfg_reload     = uartrxfa_pkg::TIMEOUT_RELOAD_RST;
      cfg_term_en    = uartrxfa_pkg::TERM_ENABLE_RST;
      cfg_term_a     = uartrxfa_pkg::TERM_FIRST_RST;
      cfg_term_b     = uartrxfa_pkg::TERM_SECOND_RST;
      burst_left     = 0;
      phase_words    = 0;
      sent_words     = 0;
      bytes_stored   = 0;
      closes_term    = 0;
      closes_idle    = 0;
      closes_full    = 0;
      csr_writes     = 0;
      rsp_count      = 0;
      mismatch_count = 0;
      quiet_cycles   = 0;
      stall_span     = 0;
      stall_style    = 0;
      stall_phase    = '0;

      add_word(uartrxfa_pkg::MODE_TICK,    8'h00, 8'h00, 1'b1, 1'b0, 9'd0, 1'b0, 1'b0, 8'h00);
      add_word(uartrxfa_pkg::MODE_RELEASE, 8'h00, 8'h00, 1'b1, 1'b0, 9'd0, 1'b0, 1'b0, 8'h00);
      add_word(uartrxfa_pkg::MODE_BYTE,    8'h00, 8'h00, 1'b1, 1'b0, 9'd0, 1'b1, 1'b1, 8'h00);
      add_word(uartrxfa_pkg::MODE_BYTE,    8'hFF, 8'h00, 1'b1, 1'b0, 9'd0, 1'b1, 1'b1, 8'h00);
      add_word(uartrxfa_pkg::MODE_BYTE,    8'h0D, 8'h00, 1'b1, 1'b0, 9'd0, 1'b1, 1'b1, 8'h00);
      add_word(uartrxfa_pkg::MODE_BYTE,    8'h09, 8'h00, 1'b1, 1'b1, 9'd4, 1'b0, 1'b1, 8'h00);
      add_word(uartrxfa_pkg::MODE_BYTE,    8'h55, 8'h00, 1'b1, 1'b1, 9'd4, 1'b0, 1'b0, 8'h00);
      add_word(uartrxfa_pkg::MODE_READ,    8'h00, 8'h00, 1'b1, 1'b1, 9'd4, 1'b0, 1'b0, 8'h00);
      add_word(uartrxfa_pkg::MODE_READ,    8'h00, 8'h01, 1'b1, 1'b1, 9'd4, 1'b0, 1'b0, 8'hFF);
      add_word(uartrxfa_pkg::MODE_READ,    8'h00, 8'h03, 1'b1, 1'b1, 9'd4, 1'b0, 1'b0, 8'h09);
      add_word(uartrxfa_pkg::MODE_RELEASE, 8'h00, 8'h00, 1'b1, 1'b0, 9'd4, 1'b0, 1'b0, 8'h00);
      add_word(uartrxfa_pkg::MODE_BYTE,    8'hA5, 8'h00, 1'b1, 1'b0, 9'd4, 1'b1, 1'b1, 8'h00);
      add_csr(uartrxfa_pkg::CSR_TIMEOUT_RELOAD, 8'd1);
      add_word(uartrxfa_pkg::MODE_BYTE,    8'h11, 8'h00, 1'b1, 1'b0, 9'd4, 1'b1, 1'b1, 8'h00);
      add_word(uartrxfa_pkg::MODE_TICK,    8'h00, 8'h00, 1'b1, 1'b0, 9'd4, 1'b1, 1'b0, 8'h00);
      add_word(uartrxfa_pkg::MODE_BYTE,    8'h22, 8'h00, 1'b1, 1'b1, 9'd2, 1'b0, 1'b0, 8'h00);
      add_word(uartrxfa_pkg::MODE_TICK,    8'h00, 8'h00, 1'b1, 1'b1, 9'd2, 1'b0, 1'b0, 8'h00);
      add_word(uartrxfa_pkg::MODE_RELEASE, 8'h00, 8'h00, 1'b1, 1'b0, 9'd2, 1'b0, 1'b0, 8'h00);
      add_csr(uartrxfa_pkg::CSR_TIMEOUT_RELOAD, 8'd0);
      add_word(uartrxfa_pkg::MODE_BYTE,    8'h33, 8'h00, 1'b1, 1'b0, 9'd2, 1'b1, 1'b1, 8'h00);
      add_word(uartrxfa_pkg::MODE_BYTE,    8'h44, 8'h00, 1'b1, 1'b1, 9'd1, 1'b0, 1'b0, 8'h00);
      add_word(uartrxfa_pkg::MODE_RELEASE, 8'h00, 8'h00, 1'b1, 1'b0, 9'd1, 1'b0, 1'b0, 8'h00);
      add_csr(uartrxfa_pkg::CSR_TERM_ENABLE, 8'd0);
      add_csr(uartrxfa_pkg::CSR_TIMEOUT_RELOAD, 8'd127);
      add_word(uartrxfa_pkg::MODE_BYTE,    8'h0D, 8'h00, 1'b1, 1'b0, 9'd1, 1'b1, 1'b1, 8'h00);
      add_word(uartrxfa_pkg::MODE_BYTE,    8'h09, 8'h00, 1'b1, 1'b0, 9'd1, 1'b1, 1'b1, 8'h00);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].is_csr) begin
            settle_block();
            write_csr(script[i].reg_idx, script[i].reg_val);
         end else begin
            send_word(script[i].mode, script[i].bval, script[i].ridx,
                      script[i].known, script[i].want);
         end
      end

      // fill the rest of the store so the frame closes full
      for (int i = 2; i < STORE_DEPTH; i++) begin
         if (i % 16 == 0)
            send_word(uartrxfa_pkg::MODE_TICK, 8'h00, 8'h00, 1'b0, '0);
         send_word(uartrxfa_pkg::MODE_BYTE, 8'($urandom), 8'h00, 1'b0, '0);
      end
      send_word(uartrxfa_pkg::MODE_READ, 8'h00, 8'hFF, 1'b0, '0);
      send_word(uartrxfa_pkg::MODE_READ, 8'h00, 8'h00, 1'b0, '0);
      send_word(uartrxfa_pkg::MODE_RELEASE, 8'h00, 8'h00, 1'b0, '0);

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         settle_block();
         case (phase % 4)
            0:       write_csr(uartrxfa_pkg::CSR_TIMEOUT_RELOAD, 8'd1);
            1:       write_csr(uartrxfa_pkg::CSR_TIMEOUT_RELOAD, 8'd127);
            default: write_csr(uartrxfa_pkg::CSR_TIMEOUT_RELOAD, 8'($urandom_range(2, 8)));
         endcase
         write_csr(uartrxfa_pkg::CSR_TERM_ENABLE, (phase % 5 == 3) ? 8'd0 : 8'd1);
         case (phase % 3)
            0: begin
               write_csr(uartrxfa_pkg::CSR_TERM_FIRST, 8'h00);
               write_csr(uartrxfa_pkg::CSR_TERM_SECOND, 8'hFF);
            end
            1: begin
               write_csr(uartrxfa_pkg::CSR_TERM_FIRST, 8'hFF);
               write_csr(uartrxfa_pkg::CSR_TERM_SECOND, 8'h00);
            end
            default: begin
               bv = 8'($urandom);
               write_csr(uartrxfa_pkg::CSR_TERM_FIRST, bv);
               write_csr(uartrxfa_pkg::CSR_TERM_SECOND, (phase == 8) ? bv : 8'($urandom));
            end
         endcase
         phase_words = 0;
         while (phase_words < PHASE_WORDS) begin
            pick = $urandom_range(0, 99);
            if (frame_waiting) begin
               if (pick < 65)
                  send_word(uartrxfa_pkg::MODE_RELEASE, 8'h00, 8'h00, 1'b0, '0);
               else if (pick < 85)
                  read_stored_byte();
               else if (pick < 95)
                  send_word(uartrxfa_pkg::MODE_BYTE, 8'($urandom), 8'h00, 1'b0, '0);
               else
                  send_word(uartrxfa_pkg::MODE_TICK, 8'h00, 8'h00, 1'b0, '0);
            end else if (pick < 55) begin
               if (cfg_term_en && $urandom_range(0, 7) == 0) begin
                  send_word(uartrxfa_pkg::MODE_BYTE, cfg_term_a, 8'h00, 1'b0, '0);
                  send_word(uartrxfa_pkg::MODE_BYTE, cfg_term_b, 8'h00, 1'b0, '0);
               end else begin
                  if ($urandom_range(0, 4) == 0)
                     bv = $urandom_range(0, 1) ? cfg_term_a : cfg_term_b;
                  else
                     bv = 8'($urandom);
                  send_word(uartrxfa_pkg::MODE_BYTE, bv, 8'h00, 1'b0, '0);
               end
            end else if (pick < 80) begin
               n = ($urandom_range(0, 3) == 0) ? int'(idle_left) + $urandom_range(0, 1) : 1;
               repeat (n) send_word(uartrxfa_pkg::MODE_TICK, 8'h00, 8'h00, 1'b0, '0);
            end else if (pick < 95) begin
               read_stored_byte();
            end else begin
               send_word(uartrxfa_pkg::MODE_RELEASE, 8'h00, 8'h00, 1'b0, '0);
            end
         end
      end

      settle_block();
      repeat (4) @(posedge clock);
      $display("covered %0d request words, %0d bytes stored, %0d register writes",
               sent_words, bytes_stored, csr_writes);
      $display("frames closed: %0d on terminator, %0d on idle timeout, %0d on full store",
               closes_term, closes_idle, closes_full);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
